/* sv/msdat_pkg.sv */
// Shared types, constants and helper functions for the daily alarm table.
package msdat_pkg;

	localparam int SLOTS_DEF   = 8;
	localparam int HOURS       = 24;
	localparam int MINUTES     = 60;
	localparam int FIRE_WINDOW = 2;
	localparam int RESET_HOUR  = 5;

	typedef enum logic [1:0] {
		CMD_TICK   = 2'd0,
		CMD_ADD    = 2'd1,
		CMD_DEL    = 2'd2,
		CMD_SNOOZE = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_EVAL,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic [4:0] hour;
		logic [5:0] minute;
		logic       en;
		logic       fired;
	} slot_t;

	localparam slot_t RST_SLOT = '{hour: 5'(RESET_HOUR), minute: '0, en: 1'b1, fired: 1'b0};

	// v mod 24: reciprocal 170/4096 underestimates the quotient by at most one
	function automatic logic [4:0] mod24(input logic [7:0] v);
		logic [15:0] p;
		logic [7:0]  q;
		logic [7:0]  r;
		p = 16'(v) * 16'd170;
		q = 8'(p[15:12]);
		r = v - 8'(q * 8'(HOURS));
		if (r >= 8'(HOURS)) begin
			r = r - 8'(HOURS);
		end
		return r[4:0];
	endfunction

	// v mod 60: reciprocal 273/16384, same single correction
	function automatic logic [5:0] mod60(input logic [7:0] v);
		logic [16:0] p;
		logic [7:0]  q;
		logic [7:0]  r;
		p = 17'(v) * 17'd273;
		q = 8'(p[16:14]);
		r = v - 8'(q * 8'(MINUTES));
		if (r >= 8'(MINUTES)) begin
			r = r - 8'(MINUTES);
		end
		return r[5:0];
	endfunction

endpackage

/* sv/multi_slot_daily_alarm_table.sv */
// Daily alarm table: one RAM of slots walked by a read-modify-write sequencer.
// Add, or a delete with nothing to shift: result in the cycle after accept.
// Tick and snooze: each slot scanned passes through READ then EVAL; the word ends in RESP.
// Delete: the slots above index move down in turn; each slot move is a RAM read then write.
// busy stays high through the done cycle; next word is taken in the cycle after done.
// Reset: one enabled alarm at 05:00 at once via a slot-0 flag, no clearing pass.
module multi_slot_daily_alarm_table
	import msdat_pkg::*;
#(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [1:0] cmd,
	input  logic [4:0] now_hour,
	input  logic [5:0] now_minute,
	input  logic [5:0] now_second,
	input  logic [7:0] new_hour,
	input  logic [7:0] new_minute,
	input  logic [7:0] delete_index,
	input  logic [5:0] snooze_minutes,
	output logic       done,
	output logic       fired,
	output logic       accepted,
	output logic [3:0] count
);

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int TW = $clog2(SLOTS + 1);

	state_t          state_q, state_d;
	cmd_t            cmd_in, cmd_q;
	logic [IW-1:0]   idx_q;
	logic [TW-1:0]   total_q;
	logic [4:0]      hr_q;
	logic [5:0]      mn_q;
	logic [5:0]      snz_q;
	logic            midnight_q, sec_ok_q;
	logic            found_q, fired_q, accepted_q;
	logic            written0_q, use_rst_q;

	logic            we;
	logic [IW-1:0]   waddr, raddr;
	slot_t           wdata, word, tick_word, snz_word;
	logic [$bits(slot_t)-1:0] rdata;

	logic [TW-1:0]   nxt;
	logic            more_scan, more_del, full, del_ok, del_shift, hit, fclr, wrap;
	logic [6:0]      sum;

	assign cmd_in = cmd_t'(cmd);

	msdat_ram #(
		.WIDTH($bits(slot_t)),
		.DEPTH(SLOTS)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	// slot 0 reads its reset value until it is first written
	assign word = use_rst_q ? RST_SLOT : slot_t'(rdata);

	assign nxt       = TW'(idx_q) + TW'(1);
	assign more_scan = nxt < total_q;
	assign more_del  = (nxt + TW'(1)) < total_q;
	assign full      = total_q >= TW'(SLOTS);
	assign del_ok    = delete_index < 8'(total_q);
	assign del_shift = ({1'b0, delete_index} + 9'd1) < 9'(total_q);

	always_comb begin
		fclr      = midnight_q ? 1'b0 : word.fired;
		hit       = !found_q && word.en && !fclr && (word.hour == hr_q)
			&& (word.minute == mn_q) && sec_ok_q;
		tick_word = word;
		tick_word.fired = fclr | hit;
	end

	always_comb begin
		sum      = {1'b0, word.minute} + {1'b0, snz_q};
		wrap     = sum >= 7'(MINUTES);
		snz_word = word;
		snz_word.fired  = 1'b0;
		snz_word.minute = wrap ? 6'(sum - 7'(MINUTES)) : sum[5:0];
		if (wrap) begin
			snz_word.hour = (word.hour == 5'(HOURS - 1)) ? 5'd0 : word.hour + 5'd1;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					unique case (cmd_in)
						CMD_TICK, CMD_SNOOZE: state_d = (total_q == '0) ? ST_RESP : ST_READ;
						CMD_ADD:              state_d = ST_RESP;
						CMD_DEL:              state_d = (del_ok && del_shift) ? ST_READ : ST_RESP;
					endcase
				end
			end
			ST_READ: state_d = ST_EVAL;
			ST_EVAL: begin
				unique case (cmd_q)
					CMD_TICK:   state_d = (more_scan && (midnight_q || !(found_q || hit)))
						? ST_READ : ST_RESP;
					CMD_SNOOZE: state_d = (!word.fired && more_scan) ? ST_READ : ST_RESP;
					CMD_DEL:    state_d = more_del ? ST_READ : ST_RESP;
					CMD_ADD:    state_d = ST_RESP;
				endcase
			end
			ST_RESP: state_d = ST_IDLE;
		endcase
	end

	// outputs and RAM access
	always_comb begin
		busy  = state_q != ST_IDLE;
		done  = state_q == ST_RESP;
		raddr = (cmd_q == CMD_DEL) ? idx_q + IW'(1) : idx_q;
		we    = 1'b0;
		waddr = idx_q;
		wdata = word;
		unique case (state_q)
			ST_IDLE: begin
				waddr = total_q[IW-1:0];
				wdata = '{hour: mod24(new_hour), minute: mod60(new_minute), en: 1'b1,
					fired: 1'b0};
				we    = start && (cmd_in == CMD_ADD) && !full;
			end
			ST_EVAL: begin
				unique case (cmd_q)
					CMD_TICK: begin
						we    = 1'b1;
						wdata = tick_word;
					end
					CMD_SNOOZE: begin
						we    = word.fired;
						wdata = snz_word;
					end
					CMD_DEL: begin
						we    = 1'b1;
						wdata = word;
					end
					CMD_ADD: we = 1'b0;
				endcase
			end
			ST_READ, ST_RESP: we = 1'b0;
		endcase
	end

	assign fired    = fired_q;
	assign accepted = accepted_q;
	assign count    = 4'(total_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			total_q    <= TW'(1);
			written0_q <= 1'b0;
			use_rst_q  <= 1'b0;
			cmd_q      <= CMD_TICK;
			idx_q      <= '0;
			found_q    <= 1'b0;
			fired_q    <= 1'b0;
			accepted_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			written0_q <= written0_q | (we && (waddr == '0));
			use_rst_q  <= (raddr == '0) && !written0_q;
			if (state_q == ST_IDLE && start) begin
				cmd_q      <= cmd_in;
				idx_q      <= (cmd_in == CMD_DEL) ? delete_index[IW-1:0] : '0;
				found_q    <= 1'b0;
				fired_q    <= 1'b0;
				accepted_q <= (cmd_in == CMD_ADD && !full) || (cmd_in == CMD_DEL && del_ok);
				if (cmd_in == CMD_ADD && !full) begin
					total_q <= total_q + TW'(1);
				end else if (cmd_in == CMD_DEL && del_ok && !del_shift) begin
					total_q <= total_q - TW'(1);
				end
			end
			if (state_q == ST_EVAL) begin
				idx_q <= nxt[IW-1:0];
				if (cmd_q == CMD_TICK) begin
					found_q <= found_q | hit;
					fired_q <= found_q | hit;
				end
				if (cmd_q == CMD_DEL && !more_del) begin
					total_q <= total_q - TW'(1);
				end
			end
		end
	end

	// time fields need no reset
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			hr_q       <= now_hour;
			mn_q       <= now_minute;
			midnight_q <= (now_hour == '0) && (now_minute == '0) && (now_second == '0);
			sec_ok_q   <= now_second < 6'(FIRE_WINDOW);
			snz_q      <= (snooze_minutes > 6'(MINUTES - 1)) ? 6'(MINUTES - 1) : snooze_minutes;
		end
	end

	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= TW'(SLOTS))
		else $error("alarm count above table size");

	a_waddr_range: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (32'(waddr) < SLOTS))
		else $error("RAM write outside table");

	a_fired_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(done && fired) |-> (cmd_q == CMD_TICK))
		else $error("fire reported for a non-tick word");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted word did not raise busy");

	a_done_one: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

endmodule

/* sv/msdat_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module msdat_ram
	import msdat_pkg::*;
#(
	parameter int WIDTH = $bits(slot_t),
	parameter int DEPTH = SLOTS_DEF,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
